FILE: sv/reconnect_backoff_controller_defines.svh
// ----------------------------------------------------------------------------
// reconnect_backoff_controller_defines
// Assertion macros used by the checker file of the reconnect controller.
// ----------------------------------------------------------------------------
`ifndef RECONNECT_BACKOFF_CONTROLLER_DEFINES_SVH
`define RECONNECT_BACKOFF_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define RBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Types and constants of the reconnect backoff controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbc_pkg;

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_NOLINK     = 3'd1,
        MODE_CONNECTING = 3'd2,
        MODE_CONNECTED  = 3'd3,
        MODE_BACKOFF    = 3'd4,
        MODE_AUTHSTOP   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        FAIL_NONE  = 2'd0,
        FAIL_ENV   = 2'd1,
        FAIL_CRED  = 2'd2,
        FAIL_PROTO = 2'd3
    } t_fail;

    typedef enum logic [1:0] {
        REQ_POLL    = 2'd0,
        REQ_OUTCOME = 2'd1,
        REQ_RETRY   = 2'd2,
        REQ_STOP    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_AUTH_LIMIT   = 2'd1,
        CFG_BACKOFF_INIT = 2'd2,
        CFG_BACKOFF_MAX  = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned SECS_W    = 23;

    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam int unsigned      MAGIC_W   = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
    localparam int unsigned      DIV_SHIFT = 38;
    localparam int unsigned      PROD_W    = DATA_W + MAGIC_W;

    typedef struct packed {
        logic attempt;
        logic drop;
        logic offline;
        logic online;
    } t_cmds;

    typedef struct packed {
        t_mode              mode;
        t_cmds              cmds;
        t_fail              fail;
        logic [DATA_W-1:0]  delay;
    } t_rslt;

endpackage

FILE: sv/reconnect_backoff_controller.sv
// ----------------------------------------------------------------------------
// reconnect_backoff_controller
// Session reconnect controller with credential limit and doubling backoff.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// item     in   i_valid / o_stall  req_type, now_ms, link, session, outcome
// result   out  o_valid / i_stall  mode, commands, failure kind, delay, secs
// config   in   i_cfg_wr           i_cfg_idx, i_cfg_data
//
// One item per cycle while the result side does not stall.
// Session state updates at the input transfer; the seconds-left value goes
// through a subtract stage and a reciprocal-multiply stage (divide by 1000).
// A stalled result holds the whole pipeline, and o_stall follows it.
// Synchronous reset loads the register defaults and the no-link mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reconnect_backoff_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [31:0]                   i_now_ms,
    input  logic                          i_link_online,
    input  logic                          i_session_up,
    input  logic                          i_connect_ok,
    input  logic signed [7:0]             i_connect_code,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_link_state,
    output logic                          o_attempt_connect,
    output logic                          o_drop_session,
    output logic                          o_send_offline,
    output logic                          o_came_online,
    output logic [1:0]                    o_failure_kind,
    output logic [31:0]                   o_retry_delay_ms,
    output logic [rbc_pkg::SECS_W-1:0]    o_retry_seconds_left,
    input  logic                          i_cfg_wr,
    input  logic [rbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbc_pkg::DATA_W-1:0]    i_cfg_data
);
    import rbc_pkg::*;

    localparam int CW = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;

    logic                 w_adv;
    logic                 w_accept;
    t_rslt                w_rslt;
    logic                 w_bk;
    logic [TIME_BITS-1:0] w_el;
    logic [CW-1:0]        w_el_x;
    logic [CW-1:0]        w_dly_x;
    logic [CW-1:0]        w_gap;
    logic [DATA_W-1:0]    w_diff;
    logic [PROD_W-1:0]    w_prod;

    logic                 r_v1, n_v1;
    logic                 r_v2, n_v2;
    logic                 r_v3, n_v3;
    t_rslt                r_rs1, r_rs2, r_rs3;
    logic                 r_bk1;
    logic [TIME_BITS-1:0] r_el1;
    logic [DATA_W-1:0]    r_diff2;
    logic [SECS_W-1:0]    r_secs3;

    assign w_adv    = !(r_v3 && i_stall);
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;

    rbc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_req_type     (i_req_type),
        .i_now_ms       (i_now_ms),
        .i_link_online  (i_link_online),
        .i_session_up   (i_session_up),
        .i_connect_ok   (i_connect_ok),
        .i_connect_code (i_connect_code),
        .i_cfg_wr       (i_cfg_wr),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_rslt         (w_rslt),
        .o_in_backoff   (w_bk),
        .o_elapsed      (w_el)
    );

    // stage 2: time left until the retry
    assign w_el_x  = CW'(r_el1);
    assign w_dly_x = CW'(r_rs1.delay);
    assign w_gap   = w_dly_x - w_el_x;
    assign w_diff  = (r_bk1 && w_el_x < w_dly_x) ? w_gap[DATA_W-1:0] : '0;

    // stage 3: whole seconds
    assign w_prod  = PROD_W'(r_diff2) * PROD_W'(DIV_MAGIC);

    assign n_v1 = w_accept;
    assign n_v2 = r_v1;
    assign n_v3 = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rs1   <= w_rslt;
            r_bk1   <= w_bk;
            r_el1   <= w_el;
            r_rs2   <= r_rs1;
            r_diff2 <= w_diff;
            r_rs3   <= r_rs2;
            r_secs3 <= w_prod[DIV_SHIFT +: SECS_W];
        end
    end

    assign o_valid              = r_v3;
    assign o_link_state         = r_rs3.mode;
    assign o_attempt_connect    = r_rs3.cmds.attempt;
    assign o_drop_session       = r_rs3.cmds.drop;
    assign o_send_offline       = r_rs3.cmds.offline;
    assign o_came_online        = r_rs3.cmds.online;
    assign o_failure_kind       = r_rs3.fail;
    assign o_retry_delay_ms     = r_rs3.delay;
    assign o_retry_seconds_left = r_secs3;

endmodule

FILE: sv/rbc_core.sv
// ----------------------------------------------------------------------------
// rbc_core
// Configuration and session state; next-state logic for one transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbc_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_req_type,
    input  logic [31:0]                 i_now_ms,
    input  logic                        i_link_online,
    input  logic                        i_session_up,
    input  logic                        i_connect_ok,
    input  logic signed [7:0]           i_connect_code,
    input  logic                        i_cfg_wr,
    input  logic [rbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbc_pkg::DATA_W-1:0]  i_cfg_data,
    output rbc_pkg::t_rslt              o_rslt,
    output logic                        o_in_backoff,
    output logic [TIME_BITS-1:0]        o_elapsed
);
    import rbc_pkg::*;

    logic                 r_en,    n_en;
    logic [7:0]           r_limit, n_limit;
    logic [DATA_W-1:0]    r_init,  n_init;
    logic [DATA_W-1:0]    r_max,   n_max;
    t_mode                r_mode,  n_mode;
    logic [DATA_W-1:0]    r_delay, n_delay;
    logic [TIME_BITS-1:0] r_last,  n_last;
    logic [7:0]           r_cnt,   n_cnt;
    t_fail                r_fail,  n_fail;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_el_old;
    logic [DATA_W:0]      w_dbl;
    logic [DATA_W-1:0]    w_delay_up;
    logic [7:0]           w_cnt_inc;

    function automatic t_fail classify(input logic [7:0] code);
        t_fail k;
        case (code) inside
            8'hFC, 8'hFD, 8'hFE, 8'hFF, 8'h03: k = FAIL_ENV;
            8'h04, 8'h05:                      k = FAIL_CRED;
            8'h01, 8'h02:                      k = FAIL_PROTO;
            default:                           k = FAIL_NONE;
        endcase
        return k;
    endfunction

    assign w_now      = TIME_BITS'(i_now_ms);
    assign w_el_old   = w_now - r_last;
    assign w_dbl      = {r_delay, 1'b0};
    assign w_delay_up = (r_delay == '0) ? r_init :
                        (w_dbl > {1'b0, r_max}) ? r_max : w_dbl[DATA_W-1:0];
    assign w_cnt_inc  = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;

    always_comb begin
        t_mode m0;
        t_cmds cmds;
        logic  esc;
        logic  esc_now;
        t_fail why;

        n_en    = r_en;
        n_limit = r_limit;
        n_init  = r_init;
        n_max   = r_max;
        n_mode  = r_mode;
        n_delay = r_delay;
        n_last  = r_last;
        n_cnt   = r_cnt;
        n_fail  = r_fail;
        m0      = r_en ? r_mode : MODE_OFF;
        cmds    = '0;
        esc     = 1'b0;
        esc_now = 1'b0;
        why     = FAIL_NONE;

        if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE: begin
                    n_en = i_cfg_data[0];
                    if (!i_cfg_data[0]) begin
                        n_mode = MODE_OFF;
                    end else if (!r_en || r_mode == MODE_OFF) begin
                        n_mode  = MODE_NOLINK;
                        n_delay = '0;
                        n_last  = '0;
                        n_cnt   = '0;
                    end
                end
                CFG_AUTH_LIMIT:   n_limit = i_cfg_data[7:0];
                CFG_BACKOFF_INIT: n_init  = i_cfg_data;
                CFG_BACKOFF_MAX:  n_max   = i_cfg_data;
            endcase
        end else if (i_accept) begin
            n_mode = m0;
            unique case (t_req'(i_req_type))
                REQ_POLL: begin
                    if (m0 == MODE_OFF) begin
                        n_mode = m0;
                    end else if (!i_link_online) begin
                        cmds.drop = i_session_up;
                        if (m0 != MODE_AUTHSTOP) begin
                            n_mode = MODE_NOLINK;
                        end
                    end else if (i_session_up) begin
                        n_mode = m0;
                    end else if (m0 == MODE_CONNECTED) begin
                        esc     = 1'b1;
                        esc_now = 1'b1;
                        why     = FAIL_ENV;
                    end else if (m0 != MODE_AUTHSTOP && m0 != MODE_CONNECTING) begin
                        // coming from no link the delay is cleared, so it always attempts
                        if (m0 == MODE_NOLINK || r_delay == '0 ||
                            w_el_old >= TIME_BITS'(r_delay) &&
                            (TIME_BITS >= DATA_W || r_delay < (DATA_W'(1) << TIME_BITS))) begin
                            n_last       = w_now;
                            n_mode       = MODE_CONNECTING;
                            cmds.attempt = 1'b1;
                        end
                        if (m0 == MODE_NOLINK) begin
                            n_delay = '0;
                        end
                    end
                end
                REQ_OUTCOME: begin
                    if (m0 == MODE_CONNECTING) begin
                        if (i_connect_ok) begin
                            n_delay     = '0;
                            n_cnt       = '0;
                            n_fail      = FAIL_NONE;
                            n_mode      = MODE_CONNECTED;
                            cmds.online = 1'b1;
                        end else begin
                            esc = 1'b1;
                            why = classify($unsigned(i_connect_code));
                        end
                    end
                end
                REQ_RETRY: begin
                    if (m0 != MODE_OFF) begin
                        n_cnt   = '0;
                        n_delay = '0;
                        n_last  = '0;
                        n_fail  = FAIL_NONE;
                        n_mode  = MODE_NOLINK;
                    end
                end
                REQ_STOP: begin
                    cmds.offline = i_session_up;
                    cmds.drop    = i_session_up;
                    n_delay      = '0;
                    n_cnt        = '0;
                    n_mode       = r_en ? MODE_NOLINK : MODE_OFF;
                end
            endcase

            if (esc) begin
                n_fail = why;
                if (esc_now) begin
                    n_last = w_now;
                end
                if (why == FAIL_CRED) begin
                    n_cnt = w_cnt_inc;
                end else begin
                    n_cnt = '0;
                end
                if (why == FAIL_CRED && w_cnt_inc >= r_limit) begin
                    n_mode = MODE_AUTHSTOP;
                end else begin
                    n_delay = w_delay_up;
                    n_mode  = MODE_BACKOFF;
                end
            end
        end

        o_rslt.mode  = n_mode;
        o_rslt.cmds  = cmds;
        o_rslt.fail  = n_fail;
        o_rslt.delay = n_delay;
        o_in_backoff = (n_mode == MODE_BACKOFF) && (n_delay != '0);
        // an escalation stamped with this item's time has no elapsed time yet
        o_elapsed    = esc_now ? '0 : w_el_old;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b1;
            r_limit <= 8'd3;
            r_init  <= 32'd1000;
            r_max   <= 32'd60000;
            r_mode  <= MODE_NOLINK;
            r_delay <= '0;
            r_last  <= '0;
            r_cnt   <= '0;
            r_fail  <= FAIL_NONE;
        end else begin
            r_en    <= n_en;
            r_limit <= n_limit;
            r_init  <= n_init;
            r_max   <= n_max;
            r_mode  <= n_mode;
            r_delay <= n_delay;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
            r_fail  <= n_fail;
        end
    end

endmodule

FILE: sv/rbc_checker.sv
// ----------------------------------------------------------------------------
// rbc_checker
// Port-level checks of the reconnect controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reconnect_backoff_controller_defines.svh"

module rbc_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_valid,
    input  logic                       i_stall,
    input  logic [2:0]                 o_link_state,
    input  logic                       o_attempt_connect,
    input  logic                       o_came_online,
    input  logic [1:0]                 o_failure_kind,
    input  logic [31:0]                o_retry_delay_ms,
    input  logic [rbc_pkg::SECS_W-1:0] o_retry_seconds_left
);
    import rbc_pkg::*;

    `RBC_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_link_state) && $stable(o_retry_delay_ms) && $stable(o_retry_seconds_left), "stalled result changed")
    `RBC_ASSERT_IMP(a_secs_backoff, i_clk, i_rst_n, o_valid && o_retry_seconds_left != '0, o_link_state == MODE_BACKOFF && o_retry_delay_ms != '0, "seconds left outside backoff")
    `RBC_ASSERT_IMP(a_attempt_mode, i_clk, i_rst_n, o_valid && o_attempt_connect, o_link_state == MODE_CONNECTING, "attempt without connecting mode")
    `RBC_ASSERT_IMP(a_online_clean, i_clk, i_rst_n, o_valid && o_came_online, o_link_state == MODE_CONNECTED && o_failure_kind == FAIL_NONE && o_retry_delay_ms == '0, "online result not clean")

endmodule

bind reconnect_backoff_controller rbc_checker u_rbc_checker (.*);

FILE: sim/tb_reconnect_backoff_controller.sv
// ----------------------------------------------------------------------------
// tb_reconnect_backoff_controller
// Self-checking bench for the reconnect controller. Poll, outcome, retry and
// stop transfers go in with random gaps while the result side stalls at
// random. Every report is predicted from a behavioral copy of the session
// state and compared field by field. Configuration is rewritten between
// traffic phases, covering zero, saturating and inverted backoff settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reconnect_backoff_controller;

    import rbc_pkg::*;

    typedef struct packed {
        t_req              req;
        logic [31:0]       now;
        logic              link;
        logic              sess;
        logic              ok;
        logic signed [7:0] code;
    } t_req_item;

    typedef struct packed {
        t_mode             state;
        logic              attempt;
        logic              drop;
        logic              offline;
        logic              online;
        t_fail             kind;
        logic [31:0]       delay;
        logic [SECS_W-1:0] secs;
    } t_backoff_result;

    // Behavioral copy of the session state plus the queue of pending reports.
    class session_tracker;
        logic            enabled;
        logic [7:0]      auth_limit;
        logic [31:0]     init_ms;
        logic [31:0]     max_ms;
        t_mode           mode;
        logic [31:0]     delay;
        logic [31:0]     t_attempt;
        logic [7:0]      cred_fails;
        t_fail           last_fail;
        t_backoff_result expected_reports[$];
        int unsigned     errors;

        function new();
            enabled    = 1'b1;
            auth_limit = 8'd3;
            init_ms    = 32'd1000;
            max_ms     = 32'd60000;
            mode       = MODE_NOLINK;
            delay      = '0;
            t_attempt  = '0;
            cred_fails = '0;
            last_fail  = FAIL_NONE;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function t_fail classify(logic signed [7:0] code);
            if ((code >= -4 && code <= -1) || code == 3) return FAIL_ENV;
            if (code == 4 || code == 5) return FAIL_CRED;
            if (code == 1 || code == 2) return FAIL_PROTO;
            return FAIL_NONE;
        endfunction

        function void escalate(logic [31:0] t_fail_at, t_fail why);
            logic [32:0] doubled;
            last_fail = why;
            t_attempt = t_fail_at;
            if (why == FAIL_CRED) begin
                if (cred_fails != 8'hFF) cred_fails = cred_fails + 8'd1;
                if (cred_fails >= auth_limit) begin
                    mode = MODE_AUTHSTOP;
                    return;
                end
            end else begin
                cred_fails = '0;
            end
            if (delay == 0) begin
                delay = init_ms;
            end else begin
                // doubled in 33 bits so it saturates instead of wrapping
                doubled = {delay, 1'b0};
                delay = (doubled > {1'b0, max_ms}) ? max_ms : doubled[31:0];
            end
            mode = MODE_BACKOFF;
        endfunction

        function t_backoff_result predict_step(t_req_item it);
            t_backoff_result r;
            logic [31:0]     elapsed;
            r = '0;
            if (!enabled) mode = MODE_OFF;
            case (it.req)
                REQ_POLL: begin
                    if (mode != MODE_OFF) begin
                        if (!it.link) begin
                            r.drop = it.sess;
                            if (mode != MODE_AUTHSTOP) mode = MODE_NOLINK;
                        end else if (!it.sess) begin
                            if (mode == MODE_CONNECTED) begin
                                escalate(it.now, FAIL_ENV);
                            end else if (mode != MODE_AUTHSTOP && mode != MODE_CONNECTING) begin
                                if (mode == MODE_NOLINK) begin
                                    delay     = '0;
                                    t_attempt = '0;
                                end
                                elapsed = it.now - t_attempt;
                                if (delay == 0 || elapsed >= delay) begin
                                    t_attempt = it.now;
                                    mode      = MODE_CONNECTING;
                                    r.attempt = 1'b1;
                                end
                            end
                        end
                    end
                end
                REQ_OUTCOME: begin
                    // outcome outside connecting is stale and dropped
                    if (mode == MODE_CONNECTING) begin
                        if (it.ok) begin
                            delay      = '0;
                            cred_fails = '0;
                            last_fail  = FAIL_NONE;
                            mode       = MODE_CONNECTED;
                            r.online   = 1'b1;
                        end else begin
                            escalate(t_attempt, classify(it.code));
                        end
                    end
                end
                REQ_RETRY: begin
                    if (mode != MODE_OFF) begin
                        cred_fails = '0;
                        delay      = '0;
                        t_attempt  = '0;
                        last_fail  = FAIL_NONE;
                        mode       = MODE_NOLINK;
                    end
                end
                REQ_STOP: begin
                    r.offline  = it.sess;
                    r.drop     = it.sess;
                    delay      = '0;
                    cred_fails = '0;
                    mode       = enabled ? MODE_NOLINK : MODE_OFF;
                end
            endcase
            if (mode == MODE_BACKOFF && delay != 0) begin
                elapsed = it.now - t_attempt;
                if (elapsed < delay) r.secs = SECS_W'((delay - elapsed) / 32'd1000);
            end
            r.state = mode;
            r.kind  = last_fail;
            r.delay = delay;
            return r;
        endfunction

        function void note_request(t_req_item it);
            expected_reports.push_back(predict_step(it));
        endfunction

        function void cfg_update(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_ENABLE: begin
                    if (!data[0]) begin
                        mode = MODE_OFF;
                    end else if (!enabled || mode == MODE_OFF) begin
                        mode       = MODE_NOLINK;
                        delay      = '0;
                        t_attempt  = '0;
                        cred_fails = '0;
                    end
                    enabled = data[0];
                end
                CFG_AUTH_LIMIT:   auth_limit = data[7:0];
                CFG_BACKOFF_INIT: init_ms    = data;
                CFG_BACKOFF_MAX:  max_ms     = data;
            endcase
        endfunction

        task flag(string what, logic [31:0] got_v, logic [31:0] want_v);
            errors++;
            $display("%0t ns  %s: got %0h, expected %0h", $time, what, got_v, want_v);
        endtask

        task check_report(t_backoff_result got);
            t_backoff_result want;
            if (expected_reports.size() == 0) begin
                flag("report with nothing pending", got.delay, 0);
                return;
            end
            want = expected_reports.pop_front();
            if (got.state !== want.state)     flag("link_state", got.state, want.state);
            if (got.attempt !== want.attempt) flag("attempt_connect", got.attempt, want.attempt);
            if (got.drop !== want.drop)       flag("drop_session", got.drop, want.drop);
            if (got.offline !== want.offline) flag("send_offline", got.offline, want.offline);
            if (got.online !== want.online)   flag("came_online", got.online, want.online);
            if (got.kind !== want.kind)       flag("failure_kind", got.kind, want.kind);
            if (got.delay !== want.delay)     flag("retry_delay_ms", got.delay, want.delay);
            if (got.secs !== want.secs)       flag("retry_seconds_left", got.secs, want.secs);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_req_type;
    logic [31:0]           i_now_ms;
    logic                  i_link_online;
    logic                  i_session_up;
    logic                  i_connect_ok;
    logic signed [7:0]     i_connect_code;
    logic                  o_valid;
    logic                  i_stall;
    logic [2:0]            o_link_state;
    logic                  o_attempt_connect;
    logic                  o_drop_session;
    logic                  o_send_offline;
    logic                  o_came_online;
    logic [1:0]            o_failure_kind;
    logic [31:0]           o_retry_delay_ms;
    logic [SECS_W-1:0]     o_retry_seconds_left;
    logic                  i_cfg_wr;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [DATA_W-1:0]     i_cfg_data;

    session_tracker sb;
    logic           calm = 1'b0;  // no gaps and no stalls while set
    logic [31:0]    now_t = '0;
    logic           link_up = 1'b1;
    logic           sess_up = 1'b0;

    reconnect_backoff_controller i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_req_type          (i_req_type),
        .i_now_ms            (i_now_ms),
        .i_link_online       (i_link_online),
        .i_session_up        (i_session_up),
        .i_connect_ok        (i_connect_ok),
        .i_connect_code      (i_connect_code),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_link_state        (o_link_state),
        .o_attempt_connect   (o_attempt_connect),
        .o_drop_session      (o_drop_session),
        .o_send_offline      (o_send_offline),
        .o_came_online       (o_came_online),
        .o_failure_kind      (o_failure_kind),
        .o_retry_delay_ms    (o_retry_delay_ms),
        .o_retry_seconds_left(o_retry_seconds_left),
        .i_cfg_wr            (i_cfg_wr),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_req_item mk(t_req req, logic [31:0] now, logic link, logic sess,
                                     logic ok, logic signed [7:0] code);
        t_req_item it;
        it.req  = req;
        it.now  = now;
        it.link = link;
        it.sess = sess;
        it.ok   = ok;
        it.code = code;
        return it;
    endfunction

    function automatic logic signed [7:0] pick_code();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return 8'(4 + $urandom_range(0, 1));
        if (sel < 50) return ($urandom_range(0, 4) == 0) ? 8'sd3 : -8'($urandom_range(1, 4));
        if (sel < 70) return 8'(1 + $urandom_range(0, 1));
        return 8'($urandom);
    endfunction

    // Mostly well-formed traffic: outcomes follow attempts, time moves forward
    // and often lands right on the end of the backoff window.
    function automatic t_req_item next_item();
        t_req_item   it;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sb.mode == MODE_BACKOFF && sel < 15)
            now_t = sb.t_attempt + sb.delay - 32'd1 + 32'($urandom_range(0, 2));
        else if (sel < 55) now_t = now_t + 32'($urandom_range(0, 1500));
        else if (sel < 80) now_t = now_t + 32'($urandom_range(0, 20000));
        else if (sel < 97) now_t = now_t + 32'($urandom_range(0, 70000));
        else now_t = $urandom;

        if (link_up) link_up = ($urandom_range(0, 24) != 0);
        else link_up = ($urandom_range(0, 2) == 0);
        if (!link_up && $urandom_range(0, 1) == 0) sess_up = 1'b0;
        if ($urandom_range(0, 32) == 0) sess_up = ~sess_up;

        if ($urandom_range(0, 19) == 0) begin
            // noise
            it = mk(t_req'($urandom_range(0, 3)), $urandom, 1'($urandom), 1'($urandom),
                    1'($urandom), 8'($urandom));
            return it;
        end
        it = mk(REQ_POLL, now_t, link_up, sess_up, 1'($urandom), 8'($urandom));
        sel = $urandom_range(0, 99);
        if (sb.mode == MODE_CONNECTING && sel < 80) begin
            it.req  = REQ_OUTCOME;
            it.ok   = ($urandom_range(0, 2) == 0);
            it.code = pick_code();
            if (it.ok) sess_up = 1'b1;
        end else if (sel < 80) begin
            it.req = REQ_POLL;
        end else if (sel < 88) begin
            it.req  = REQ_OUTCOME;
            it.code = pick_code();
        end else if (sel < 95) begin
            it.req = REQ_RETRY;
        end else begin
            it.req  = REQ_STOP;
            sess_up = 1'b0;
        end
        return it;
    endfunction

    task automatic send_item(t_req_item it);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= it.req;
        i_now_ms       <= it.now;
        i_link_online  <= it.link;
        i_session_up   <= it.sess;
        i_connect_ok   <= it.ok;
        i_connect_code <= it.code;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(it);
    endtask

    task automatic drain_reports();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Registers only change with nothing in flight; enable goes last.
    task automatic configure(logic en, logic [7:0] lim, logic [31:0] init_v, logic [31:0] max_v);
        t_cfg_idx    order [4];
        logic [31:0] data;
        order = '{CFG_AUTH_LIMIT, CFG_BACKOFF_INIT, CFG_BACKOFF_MAX, CFG_ENABLE};
        i_valid <= 1'b0;
        drain_reports();
        foreach (order[k]) begin
            data = $urandom;
            case (order[k])
                CFG_ENABLE:       data[0] = en;
                CFG_AUTH_LIMIT:   data[7:0] = lim;
                CFG_BACKOFF_INIT: data = init_v;
                CFG_BACKOFF_MAX:  data = max_v;
            endcase
            i_cfg_wr   <= 1'b1;
            i_cfg_idx  <= order[k];
            i_cfg_data <= data;
            @(posedge i_clk);
            sb.cfg_update(order[k], data);
        end
        i_cfg_wr <= 1'b0;
    endtask

    task automatic run_traffic(int unsigned items);
        for (int unsigned k = 0; k < items; k++) begin
            if (k % 60 == 0) calm = ($urandom_range(0, 3) == 0);
            send_item(next_item());
        end
    endtask

    always @(posedge i_clk) begin
        t_backoff_result got;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got.state   = t_mode'(o_link_state);
            got.attempt = o_attempt_connect;
            got.drop    = o_drop_session;
            got.offline = o_send_offline;
            got.online  = o_came_online;
            got.kind    = t_fail'(o_failure_kind);
            got.delay   = o_retry_delay_ms;
            got.secs    = o_retry_seconds_left;
            sb.check_report(got);
        end
    end

    initial begin : result_sink
        int unsigned hold;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 11);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        i_valid        = 1'b0;
        i_req_type     = REQ_POLL;
        i_now_ms       = '0;
        i_link_online  = 1'b0;
        i_session_up   = 1'b0;
        i_connect_ok   = 1'b0;
        i_connect_code = '0;
        i_cfg_wr       = 1'b0;
        i_cfg_idx      = CFG_ENABLE;
        i_cfg_data     = '0;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk through the session life cycle under reset settings
        send_item(mk(REQ_POLL,    32'd0,    1'b0, 1'b1, 1'b0, 8'sd0));  // link loss drops session
        send_item(mk(REQ_POLL,    32'd10,   1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_OUTCOME, 32'd20,   1'b1, 1'b0, 1'b0, 8'sd4));
        send_item(mk(REQ_POLL,    32'd500,  1'b1, 1'b0, 1'b0, 8'sd0));  // window still open
        send_item(mk(REQ_POLL,    32'd1010, 1'b1, 1'b0, 1'b0, 8'sd0));  // exactly at delay
        send_item(mk(REQ_OUTCOME, 32'd1020, 1'b1, 1'b0, 1'b0, -8'sd4)); // doubles
        send_item(mk(REQ_OUTCOME, 32'd1030, 1'b1, 1'b0, 1'b0, 8'sd4));  // stale
        send_item(mk(REQ_POLL,    32'd3010, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_OUTCOME, 32'd3020, 1'b1, 1'b0, 1'b1, 8'sd0));
        send_item(mk(REQ_POLL,    32'd3050, 1'b1, 1'b1, 1'b0, 8'sd0));
        send_item(mk(REQ_POLL,    32'd3100, 1'b1, 1'b0, 1'b0, 8'sd0));  // connected, session gone
        send_item(mk(REQ_RETRY,   32'd3150, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_POLL,    32'd3200, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_OUTCOME, 32'd3210, 1'b1, 1'b0, 1'b0, 8'sd1));
        send_item(mk(REQ_STOP,    32'd3300, 1'b1, 1'b1, 1'b0, 8'sd0));  // offline notice
        send_item(mk(REQ_POLL,    32'd5000, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_OUTCOME, 32'd5010, 1'b1, 1'b0, 1'b0, 8'sd5));
        send_item(mk(REQ_POLL,    32'd6000, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_OUTCOME, 32'd6010, 1'b1, 1'b0, 1'b0, 8'sd4));
        send_item(mk(REQ_POLL,    32'd8000, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_OUTCOME, 32'd8010, 1'b1, 1'b0, 1'b0, 8'sd4));  // hits auth limit
        send_item(mk(REQ_POLL,    32'd9000, 1'b0, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_RETRY,   32'd9100, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_POLL,    32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'sd0));
        send_item(mk(REQ_OUTCOME, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'sd127));
        send_item(mk(REQ_POLL,    32'h0000_0400, 1'b1, 1'b0, 1'b0, 8'sd0)); // across the wrap
        send_item(mk(REQ_OUTCOME, 32'h0000_0410, 1'b1, 1'b0, 1'b0, -8'sd128));

        configure(1'b1, 8'd3,   32'd1000,       32'd60000);
        run_traffic(180);
        configure(1'b1, 8'd1,   32'd0,          32'd60000);
        run_traffic(180);
        configure(1'b1, 8'd255, 32'd1,          32'hFFFF_FFFF);
        run_traffic(180);
        configure(1'b1, 8'd2,   32'hFFFF_FFFF,  32'hFFFF_FFFF);
        run_traffic(180);
        configure(1'b1, 8'd4,   32'd5000,       32'd3000);
        run_traffic(180);
        configure(1'b1, 8'd0,   32'd1000,       32'd0);
        run_traffic(180);
        configure(1'b0, 8'd3,   32'd1000,       32'd60000);
        run_traffic(80);
        repeat (4) begin
            configure(1'b1, 8'($urandom_range(1, 255)),
                      $urandom_range(0, 1) ? 32'($urandom_range(0, 8000)) : $urandom,
                      $urandom_range(0, 1) ? 32'($urandom_range(0, 80000)) : $urandom);
            run_traffic(125);
        end

        i_valid <= 1'b0;
        drain_reports();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: reconnect_backoff_controller.f
+incdir+sv
sv/rbc_pkg.sv
sv/rbc_core.sv
sv/reconnect_backoff_controller.sv
sv/rbc_checker.sv
sim/tb_reconnect_backoff_controller.sv
